>>> rtl/core/fpfi_pkg.sv
// ----------------------------------------------------------------------------
// fpfi_pkg
// Shared constants, types and control program of the fractional phase
// interpolator.
// ----------------------------------------------------------------------------
package fpfi_pkg;

    localparam int TAPS       = 8;
    localparam int PHASES     = 12;
    localparam int COEF_WORDS = 48;
    localparam int MAX_OUT    = 4;

    localparam int STEP_W     = 17;
    localparam int SPAN_W     = 26;
    localparam int POS_W      = 27;
    localparam int CNT_W      = 11;
    localparam int SMP_W      = 16;
    localparam int COEF_W     = 16;
    localparam int ADDR_W     = 6;
    localparam int ACC_W      = 32;
    localparam int TAP_W      = 3;
    localparam int NOUT_W     = 3;
    localparam int PHASE_W    = 4;
    localparam int ACT_W      = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 26;
    localparam int IN_DATA_W  = 40;
    localparam int FRAC_W     = 16;

    localparam logic [STEP_W-1:0]  STEP_MIN   = 17'd16384;
    localparam logic [STEP_W-1:0]  STEP_RESET = 17'd65536;
    localparam logic [CNT_W-1:0]   CNT_RESET  = 11'd8;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 11'd2047;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 4'(PHASES - 1);
    localparam logic [TAP_W-1:0]   TAP_LAST   = 3'(TAPS - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_PUSH  = 2'd1,
        ACT_START = 2'd2
    } t_action;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STEP = 2'd0,
        CFG_SPAN = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PHASE,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_ROUND
    } t_step;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_ACCEPT,
        J_CHECK,
        J_TAPS
    } t_jump;

    typedef struct packed {
        logic  accept;
        logic  emit_chk;
        logic  phase_ld;
        logic  mac_rd;
        logic  round_ld;
        t_jump jump;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic go;
        logic stall;
        logic cond;
        logic tap_last;
    } t_status;

    function automatic t_ctrl ucode(input t_step s);
        t_ctrl w;
        w        = '0;
        w.jump   = J_NEXT;
        w.target = S_IDLE;
        unique case (s)
            S_IDLE: begin
                w.accept = 1'b1;
                w.jump   = J_ACCEPT;
                w.target = S_CHECK;
            end
            S_CHECK: begin
                w.emit_chk = 1'b1;
                w.jump     = J_CHECK;
                w.target   = S_IDLE;
            end
            S_PHASE: begin
                w.phase_ld = 1'b1;
            end
            S_MAC: begin
                w.mac_rd = 1'b1;
                w.jump   = J_TAPS;
            end
            S_DRAIN1: begin
                w.jump = J_NEXT;
            end
            S_DRAIN2: begin
                w.jump = J_NEXT;
            end
            S_ROUND: begin
                w.round_ld = 1'b1;
                w.jump     = J_GOTO;
                w.target   = S_CHECK;
            end
            default: begin
                w.jump   = J_GOTO;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/fpfi_sequencer.sv
// ----------------------------------------------------------------------------
// fpfi_sequencer
// Step counter over the control program with conditional jumps on datapath
// status.
// ----------------------------------------------------------------------------
module fpfi_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpfi_pkg::t_status i_status,
    output fpfi_pkg::t_ctrl   o_ctrl
);
    import fpfi_pkg::*;

    t_step r_step;
    t_step n_step;
    t_step step_inc;
    t_ctrl ctrl;

    assign ctrl     = ucode(r_step);
    assign o_ctrl   = ctrl;
    assign step_inc = t_step'(r_step + 3'd1);

    always_comb begin
        n_step = r_step;
        unique case (ctrl.jump)
            J_NEXT:   n_step = step_inc;
            J_GOTO:   n_step = ctrl.target;
            J_ACCEPT: if (i_status.go) n_step = ctrl.target;
            J_CHECK: begin
                if (!i_status.stall) begin
                    n_step = i_status.cond ? step_inc : ctrl.target;
                end
            end
            J_TAPS:   if (i_status.tap_last) n_step = step_inc;
            default:  n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> rtl/core/fpfi_datapath.sv
// ----------------------------------------------------------------------------
// fpfi_datapath
// Sample window, coefficient memory, shared multiply-accumulate, read
// position, configuration registers and output register.
// ----------------------------------------------------------------------------
module fpfi_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fpfi_pkg::t_ctrl                     i_ctrl,
    output fpfi_pkg::t_status                   o_status,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // action
    input  logic [fpfi_pkg::ACT_W-1:0]          s_axis_tuser,
    // coef_addr, coef_value, sample_in, zero pad
    input  logic [fpfi_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sample_out
    output logic [fpfi_pkg::SMP_W-1:0]          m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpfi_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [fpfi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fpfi_pkg::*;

    localparam int RND_W = ACC_W + 1 - 15;

    logic                     s_acc;
    logic [ACT_W-1:0]         act;
    logic [ADDR_W-1:0]        in_addr;
    logic signed [COEF_W-1:0] in_coef;
    logic signed [SMP_W-1:0]  in_smp;

    logic [STEP_W-1:0]        r_stepq;
    logic [SPAN_W-1:0]        r_span;
    logic [STEP_W-1:0]        step_eff;

    logic signed [SMP_W-1:0]  r_win [TAPS];
    logic [CNT_W-1:0]         r_cnt;
    logic [POS_W-1:0]         r_pos;
    logic [NOUT_W-1:0]        r_nout;

    logic signed [COEF_W-1:0] r_coef_mem [COEF_WORDS];
    logic signed [COEF_W-1:0] r_coef;

    logic [PHASE_W-1:0]       r_phase;
    logic [FRAC_W+3:0]        ph_prod;
    logic [TAP_W-1:0]         r_tap;
    logic [TAP_W-1:0]         r_k_d;
    logic                     r_rd_v;
    logic                     r_mul_v;
    logic [PHASE_W-1:0]       rd_row;
    logic [1:0]               rd_col;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [ACC_W-1:0]  r_prod;
    logic [ACC_W-1:0]         r_acc;

    logic signed [ACC_W:0]    rnd_sum;
    logic signed [RND_W-1:0]  rnd_q;
    logic [SMP_W-1:0]         sat;
    logic [SMP_W-1:0]         r_res;
    logic                     r_pend;

    logic                     cond;
    logic                     stall;
    logic                     load_out;
    logic                     r_m_valid;
    logic [SMP_W-1:0]         r_m_data;
    logic                     r_m_last;

    assign s_axis_tready = i_ctrl.accept;
    assign o_cfg_ready   = 1'b1;
    assign s_acc         = s_axis_tvalid & i_ctrl.accept;
    assign act           = s_axis_tuser;
    assign in_addr       = s_axis_tdata[ADDR_W-1:0];
    assign in_coef       = s_axis_tdata[ADDR_W+COEF_W-1:ADDR_W];
    assign in_smp        = s_axis_tdata[ADDR_W+COEF_W+SMP_W-1:ADDR_W+COEF_W];

    assign step_eff = (r_stepq < STEP_MIN) ? STEP_MIN : r_stepq;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stepq <= STEP_RESET;
            r_span  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_STEP: r_stepq <= i_cfg_data[STEP_W-1:0];
                CFG_SPAN: r_span  <= i_cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (s_acc && act == ACT_LOAD && in_addr < ADDR_W'(COEF_WORDS)) begin
            r_coef_mem[in_addr] <= in_coef;
        end
        if (i_ctrl.mac_rd) begin
            r_coef <= r_coef_mem[rd_addr];
        end
    end

    // window, buffer count and read position
    assign ph_prod = {1'b0, r_pos[FRAC_W-1:0], 3'b000} + {2'b00, r_pos[FRAC_W-1:0], 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) r_win[i] <= '0;
            r_cnt  <= CNT_RESET;
            r_pos  <= '0;
            r_nout <= '0;
            r_pend <= 1'b0;
        end else begin
            if (s_acc && act == ACT_PUSH) begin
                for (int i = 0; i < TAPS - 1; i++) r_win[i] <= r_win[i+1];
                r_win[TAPS-1] <= in_smp;
                if (r_cnt < CNT_MAX) r_cnt <= r_cnt + 1'b1;
            end
            if (s_acc && act == ACT_START) begin
                r_pos <= '0;
                r_cnt <= CNT_RESET;
            end
            if (o_status.go) begin
                r_nout <= '0;
                r_pend <= 1'b0;
            end else if (i_ctrl.round_ld) begin
                r_pos  <= r_pos + {{(POS_W-STEP_W){1'b0}}, step_eff};
                r_nout <= r_nout + 1'b1;
                r_pend <= 1'b1;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end
        end
    end

    // tap addressing: first half row p, second half row 11-p reversed
    assign rd_row  = r_tap[TAP_W-1] ? (PHASE_LAST - r_phase) : r_phase;
    assign rd_col  = r_tap[TAP_W-1] ? ~r_tap[1:0] : r_tap[1:0];
    assign rd_addr = {rd_row, rd_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap   <= '0;
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_rd_v  <= i_ctrl.mac_rd;
            r_mul_v <= r_rd_v;
            if (i_ctrl.phase_ld) begin
                r_tap <= '0;
            end else if (i_ctrl.mac_rd) begin
                r_tap <= r_tap + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.phase_ld) begin
            r_phase <= ph_prod[FRAC_W+3:FRAC_W];
        end
        if (i_ctrl.mac_rd) begin
            r_k_d <= r_tap;
        end
        if (r_rd_v) begin
            r_prod <= r_win[r_k_d] * r_coef;
        end
        if (i_ctrl.phase_ld) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_ctrl.round_ld) begin
            r_res <= sat;
        end
    end

    // round half up by 15, saturate to 16 bits
    assign rnd_sum = $signed({r_acc[ACC_W-1], r_acc}) + 33'sd16384;
    assign rnd_q   = rnd_sum[ACC_W:15];

    always_comb begin
        if (!rnd_q[RND_W-1] && rnd_q[RND_W-2:SMP_W-1] != '0) begin
            sat = {1'b0, {(SMP_W-1){1'b1}}};
        end else if (rnd_q[RND_W-1] && rnd_q[RND_W-2:SMP_W-1] != '1) begin
            sat = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            sat = rnd_q[SMP_W-1:0];
        end
    end

    assign cond = (r_nout < NOUT_W'(MAX_OUT))
               && (r_pos < {1'b0, r_span})
               && (({1'b0, r_pos[POS_W-1:FRAC_W]} + (CNT_W+1)'(TAPS)) == {1'b0, r_cnt});

    assign stall    = r_pend & r_m_valid & ~m_axis_tready;
    assign load_out = i_ctrl.emit_chk & r_pend & ~stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_data <= r_res;
            r_m_last <= ~cond;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    assign o_status.go       = s_acc & (act == ACT_PUSH || act == ACT_START);
    assign o_status.stall    = stall;
    assign o_status.cond     = cond;
    assign o_status.tap_last = (r_tap == TAP_LAST);

endmodule

>>> rtl/core/fractional_phase_fir_interpolator_top.sv
// ----------------------------------------------------------------------------
// fractional_phase_fir_interpolator_top
// Eight-tap, twelve-phase fractional FIR interpolator over an upsampled
// sample stream.
//
// usage
//   s_axis carries one transaction per item: tuser selects load coefficient,
//   push sample or start batch; tdata holds coefficient address and value
//   and the sample. m_axis returns interpolated samples, tlast on an item's
//   last. the user must write cfg step and span only while idle, unenforced.
// processing
//   a load leaves s_axis ready for the next item; a push or start yields n
//   outputs (n up to 4). each output is 8 multiply-accumulates through the
//   one shared multiplier fed by the single-port coefficient memory, plus
//   phase, drain and rounding steps; the first output reaches m_axis after
//   the check, phase, tap, drain and round steps and a second check.
// reset
//   window cleared, count 8, position 0, step 65536, span 0; coefficients
//   must be loaded before use.
// stall
//   the output register holds one result; a later result waits in the
//   sequencer until it is taken, and s_axis stays not ready until the
//   last result of the item is in the output register.
// ----------------------------------------------------------------------------
module fractional_phase_fir_interpolator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // action
    input  logic [fpfi_pkg::ACT_W-1:0]       s_axis_tuser,
    // coef_addr [5:0], coef_value [21:6], sample_in [37:22], zero pad
    input  logic [fpfi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // sample_out [15:0]
    output logic [fpfi_pkg::SMP_W-1:0]       m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fpfi_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [fpfi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fpfi_pkg::*;

    t_ctrl   ctrl;
    t_status status;

    fpfi_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    fpfi_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_status      (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

endmodule

>>> rtl/core/fpfi_checker.sv
// ----------------------------------------------------------------------------
// fpfi_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module fpfi_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [fpfi_pkg::ACT_W-1:0]       s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fpfi_pkg::SMP_W-1:0]       m_axis_tdata,
    input logic                             m_axis_tlast
);
    import fpfi_pkg::*;

    logic s_xfer;
    assign s_xfer = s_axis_tvalid & s_axis_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // a result that is not last means the item is still being worked on
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during a result run");

    // a push or start occupies the sequencer
    a_busy_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && (s_axis_tuser == ACT_PUSH || s_axis_tuser == ACT_START)
            |=> !s_axis_tready)
        else $error("input ready right after push or start");

    // no result can appear in the cycle after a transaction
    a_no_instant_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("output appeared too early");

endmodule

bind fractional_phase_fir_interpolator_top fpfi_checker u_fpfi_checker (.*);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fractional phase FIR interpolator. The
// coefficient table is filled first, then directed and random streams of
// loads, pushes and batch starts are sent under random idling on both
// stream sides. A cycle-free model of the window, count, position and
// filter arithmetic predicts every output sample and its tlast flag, and
// the monitor checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfi_pkg::*;

    localparam logic [ACT_W-1:0]      ACT_NONE      = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE0    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE1    = 2'd3;
    localparam int                    SETTLE_CYCLES = 64;
    localparam int unsigned           HOLD_CYCLES   = 400;
    localparam logic [CFG_DATA_W-1:0] ONE_SAMPLE    = 26'd65536;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] addr;
        logic [COEF_W-1:0] coef;
        logic [SMP_W-1:0]  smp;
    } t_item;

    typedef struct {
        logic [SMP_W-1:0] value;
        logic             last;
    } t_interp_out;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [ACT_W-1:0]      s_axis_tuser  = '0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SMP_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // predictor state
    logic signed [COEF_W-1:0] coef_mem [COEF_WORDS];
    logic signed [SMP_W-1:0]  win [TAPS];
    logic [CNT_W-1:0]         fill_cnt  = CNT_RESET;
    logic [POS_W-1:0]         rd_pos    = '0;
    logic [STEP_W-1:0]        step_reg  = STEP_RESET;
    logic [SPAN_W-1:0]        span_reg  = '0;

    t_item       pend_items [$];
    t_interp_out expected_samples [$];
    t_item       tx_item;
    t_interp_out want;
    int unsigned queued_cnt    = 0;
    int unsigned accepted_cnt  = 0;
    int unsigned predicted_cnt = 0;
    int unsigned tx_gap        = 0;
    int unsigned rx_stall      = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_done     = 0;
    int unsigned hold_left     = 0;
    int unsigned err_cnt       = 0;
    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;

    fractional_phase_fir_interpolator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap(bit enable);
        if (!enable || $urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SMP_W-1:0] rnd16();
        return SMP_W'($urandom);
    endfunction

    function automatic logic [ADDR_W-1:0] rnd6();
        return ADDR_W'($urandom);
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h7FFF;
        if (r < 20) return 16'h8000;
        return rnd16();
    endfunction

    function automatic void add_item(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] addr,
                                     logic [COEF_W-1:0] coef, logic [SMP_W-1:0] smp);
        pend_items.push_back('{action: act, addr: addr, coef: coef, smp: smp});
        queued_cnt++;
    endfunction

    function automatic void emit_outputs();
        logic [STEP_W-1:0] eff_step;
        logic [SMP_W-1:0]  vals [MAX_OUT];
        int                n;
        int                phase;
        int                acc;
        longint            rounded;
        eff_step = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;
        n = 0;
        while (n < MAX_OUT && rd_pos < span_reg &&
               int'(rd_pos >> FRAC_W) + TAPS == int'(fill_cnt)) begin
            phase = (int'(rd_pos[FRAC_W-1:0]) * PHASES) >> FRAC_W;
            acc = 0;
            for (int k = 0; k < TAPS / 2; k++) begin
                acc += int'(win[k]) * int'(coef_mem[phase * 4 + k]);
                acc += int'(win[k + 4]) * int'(coef_mem[(PHASES - 1 - phase) * 4 + 3 - k]);
            end
            rounded = (longint'(acc) + 64'sd16384) >>> 15;
            if (rounded > 32767) rounded = 32767;
            else if (rounded < -32768) rounded = -32768;
            vals[n] = SMP_W'(rounded);
            rd_pos = rd_pos + POS_W'(eff_step);
            n++;
        end
        for (int i = 0; i < n; i++) begin
            expected_samples.push_back('{value: vals[i], last: (i == n - 1)});
        end
        predicted_cnt += n;
    endfunction

    function automatic void interp_apply(t_item it);
        case (it.action)
            ACT_LOAD: begin
                if (it.addr < COEF_WORDS) coef_mem[it.addr] = it.coef;
            end
            ACT_PUSH: begin
                for (int i = 0; i < TAPS - 1; i++) win[i] = win[i + 1];
                win[TAPS - 1] = it.smp;
                if (fill_cnt < CNT_MAX) fill_cnt++;
                emit_outputs();
            end
            ACT_START: begin
                rd_pos   = '0;
                fill_cnt = CNT_RESET;
                emit_outputs();
            end
            default: begin
            end
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_STEP: step_reg = val[STEP_W-1:0];
            CFG_SPAN: span_reg = val;
            default: begin
            end
        endcase
    endtask

    task automatic settle();
        while (accepted_cnt != queued_cnt || expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                interp_apply(tx_item);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap != 0) begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pend_items.size() != 0) begin
                    tx_item = pend_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= tx_item.action;
                    s_axis_tdata  <= {2'b00, tx_item.smp, tx_item.coef, tx_item.addr};
                    tx_gap        <= pick_gap(tx_idle_on);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall      <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall      <= pick_gap(1'b1);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                $error("sample_out %0d arrived with none expected", $signed(m_axis_tdata));
                err_cnt++;
            end else begin
                want = expected_samples.pop_front();
                if (m_axis_tdata !== want.value) begin
                    $error("sample_out expected %0d actual %0d",
                           $signed(want.value), $signed(m_axis_tdata));
                    err_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("run_last expected %0b actual %0b", want.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int unsigned       rand_items;
        int unsigned       result_base;
        int unsigned       phase_idx;
        int                r;
        int                n;
        logic [STEP_W-1:0] step_v;
        logic [SPAN_W-1:0] span_v;
        logic [ACT_W-1:0]  act;
        logic [ADDR_W-1:0] addr_v;

        for (int i = 0; i < COEF_WORDS; i++) coef_mem[i] = '0;
        for (int i = 0; i < TAPS; i++) win[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the coefficient table before any output can read it
        for (int a = 0; a < COEF_WORDS; a++) begin
            add_item(ACT_LOAD, ADDR_W'(a),
                     (a == 0) ? 16'h7FFF : (a == 1) ? 16'h8000 : rnd16(), rnd16());
        end
        settle();

        // one output per sample until the span is reached
        cfg_write(CFG_STEP, ONE_SAMPLE);
        cfg_write(CFG_SPAN, 26'(4 * 65536));
        add_item(ACT_START, 6'h3F, 16'h8000, 16'h7FFF);
        add_item(ACT_PUSH, 6'h00, 16'h7FFF, 16'h7FFF);
        add_item(ACT_PUSH, 6'h3F, 16'h0000, 16'h8000);
        add_item(ACT_PUSH, rnd6(), rnd16(), 16'h0000);
        add_item(ACT_PUSH, rnd6(), rnd16(), rnd16());
        add_item(ACT_NONE, rnd6(), rnd16(), rnd16());
        add_item(ACT_LOAD, 6'h3F, rnd16(), rnd16());
        add_item(ACT_LOAD, 6'd48, rnd16(), rnd16());
        settle();

        // span raised after the batch ended: position is stale
        cfg_write(CFG_SPAN, 26'h3FF_FFFF);
        cfg_write(CFG_SPARE0, 26'(rnd16()));
        cfg_write(CFG_SPARE1, 26'h3FF_FFFF);
        add_item(ACT_PUSH, rnd6(), rnd16(), rnd16());
        add_item(ACT_PUSH, rnd6(), rnd16(), rnd16());
        settle();

        // step below minimum, four outputs per sample
        cfg_write(CFG_STEP, '0);
        add_item(ACT_START, rnd6(), rnd16(), rnd16());
        add_item(ACT_PUSH, rnd6(), rnd16(), 16'h7FFF);
        add_item(ACT_PUSH, rnd6(), rnd16(), 16'h8000);
        settle();

        // step changed inside a running batch
        cfg_write(CFG_STEP, 26'd32768);
        add_item(ACT_LOAD, 6'd5, 16'h7FFF, rnd16());
        add_item(ACT_PUSH, rnd6(), rnd16(), rnd16());
        settle();

        cfg_write(CFG_STEP, 26'h1FFFF);
        cfg_write(CFG_SPAN, 26'(20 * 65536));
        add_item(ACT_START, rnd6(), rnd16(), rnd16());
        add_item(ACT_PUSH, rnd6(), rnd16(), rnd16());
        add_item(ACT_PUSH, rnd6(), rnd16(), rnd16());
        add_item(ACT_PUSH, rnd6(), rnd16(), rnd16());
        settle();

        cfg_write(CFG_STEP, 26'd16383);
        cfg_write(CFG_SPAN, 26'd1);
        add_item(ACT_START, rnd6(), rnd16(), rnd16());
        add_item(ACT_PUSH, rnd6(), rnd16(), rnd16());
        settle();

        cfg_write(CFG_SPAN, '0);
        add_item(ACT_START, rnd6(), rnd16(), rnd16());
        settle();

        // random phases
        rand_items  = 0;
        result_base = predicted_cnt;
        phase_idx   = 0;
        while (rand_items < 50 || predicted_cnt - result_base < 48) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (phase_idx == 0) begin
                // receiver holds off while a dense batch keeps coming
                cfg_write(CFG_STEP, 26'd20000);
                cfg_write(CFG_SPAN, 26'h3FF_FFFF);
                @(posedge i_clk);
                hold_req <= hold_req + 1;
                add_item(ACT_START, rnd6(), rnd16(), rnd16());
                for (int i = 0; i < 16; i++) add_item(ACT_PUSH, rnd6(), rnd16(), pick_sample());
                rand_items += 17;
            end else begin
                if ($urandom_range(0, 9) < 6) begin
                    r = $urandom_range(0, 99);
                    if (r < 10) step_v = STEP_W'($urandom_range(0, 16383));
                    else if (r < 15) step_v = 17'h1FFFF;
                    else if (r < 20) step_v = STEP_MIN;
                    else step_v = STEP_W'($urandom_range(16384, 131071));
                    cfg_write(CFG_STEP, {9'($urandom), step_v});
                    r = $urandom_range(0, 99);
                    if (r < 8) span_v = '0;
                    else if (r < 14) span_v = 26'h3FF_FFFF;
                    else span_v = SPAN_W'($urandom_range(1, 24 * 65536));
                    cfg_write(CFG_SPAN, span_v);
                    if ($urandom_range(0, 9) == 0) begin
                        cfg_write($urandom_range(0, 1) ? CFG_SPARE0 : CFG_SPARE1,
                                  CFG_DATA_W'($urandom));
                    end
                end
                n = $urandom_range(6, 18);
                if ($urandom_range(0, 99) < 85) begin
                    if ($urandom_range(0, 3) != 0) begin
                        add_item(ACT_START, rnd6(), rnd16(), rnd16());
                        rand_items++;
                    end
                    for (int i = 0; i < n; i++) begin
                        r = $urandom_range(0, 99);
                        if (r < 80) begin
                            add_item(ACT_PUSH, rnd6(), rnd16(), pick_sample());
                            rand_items++;
                        end else if (r < 88) begin
                            add_item(ACT_LOAD, ADDR_W'($urandom_range(0, 47)),
                                     pick_sample(), rnd16());
                            rand_items++;
                        end else if (r < 92) begin
                            add_item(ACT_START, rnd6(), rnd16(), rnd16());
                            rand_items++;
                        end else if (r < 96) begin
                            add_item(ACT_NONE, rnd6(), rnd16(), rnd16());
                        end else begin
                            add_item(ACT_LOAD, ADDR_W'($urandom_range(48, 63)),
                                     rnd16(), rnd16());
                        end
                    end
                end else begin
                    for (int i = 0; i < n; i++) begin
                        act    = ACT_W'($urandom_range(0, 3));
                        addr_v = rnd6();
                        add_item(act, addr_v, rnd16(), pick_sample());
                        if (act != ACT_NONE && !(act == ACT_LOAD && addr_v >= COEF_WORDS))
                            rand_items++;
                    end
                end
            end
            settle();
            phase_idx++;
        end

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/fpfi_pkg.sv
rtl/core/fpfi_sequencer.sv
rtl/core/fpfi_datapath.sv
rtl/core/fractional_phase_fir_interpolator_top.sv
rtl/core/fpfi_checker.sv
test/tb_top.sv
